[hw/rtl/pdt_pkg.sv]
// ----------------------------------------------------------------------------
// Periodic deadline timer bank package
// Request and result codes, sequencer states and limits shared by the bank.
// ----------------------------------------------------------------------------
package pdt_pkg;

    localparam logic [1:0] REQ_ARM  = 2'd0;
    localparam logic [1:0] REQ_STOP = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;
    localparam logic [1:0] REQ_RSVD = 2'd3;

    localparam logic KIND_ACK    = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    localparam int RESULT_LIMIT = 16;
    localparam int RES_CNT_W    = 5;
    localparam int RES_IDX_W    = 4;
    localparam int COUNT_BITS   = 32;
    localparam int SLOT_BITS    = 4;
    localparam int PORT_TIME_W  = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ARM_DIV,
        ST_PASS,
        ST_PASS_END,
        ST_TICK_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic shift;
        logic clr_done;
    } cell_ctrl_t;

endpackage

[hw/rtl/pdt_cell.sv]
// ----------------------------------------------------------------------------
// Timer slot cell
// Holds one slot of the ring and takes its neighbor's slot on every shift.
// ----------------------------------------------------------------------------
module pdt_cell #(
    parameter int TIME_BITS = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pdt_pkg::cell_ctrl_t                ctrl,
    input  logic                               d_armed,
    input  logic                               d_done,
    input  logic [TIME_BITS-1:0]               d_dl,
    input  logic [TIME_BITS-1:0]               d_per,
    input  logic [pdt_pkg::COUNT_BITS-1:0]     d_cnt,
    output logic                               q_armed,
    output logic                               q_done,
    output logic [TIME_BITS-1:0]               q_dl,
    output logic [TIME_BITS-1:0]               q_per,
    output logic [pdt_pkg::COUNT_BITS-1:0]     q_cnt
);

    logic                           armed_reg;
    logic                           done_reg;
    logic [TIME_BITS-1:0]           dl_reg;
    logic [TIME_BITS-1:0]           per_reg;
    logic [pdt_pkg::COUNT_BITS-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            done_reg  <= 1'b0;
            dl_reg    <= '0;
            per_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (ctrl.shift)
        begin
            armed_reg <= d_armed;
            done_reg  <= d_done;
            dl_reg    <= d_dl;
            per_reg   <= d_per;
            cnt_reg   <= d_cnt;
        end
        else if (ctrl.clr_done)
        begin
            done_reg <= 1'b0;
        end
    end

    assign q_armed = armed_reg;
    assign q_done  = done_reg;
    assign q_dl    = dl_reg;
    assign q_per   = per_reg;
    assign q_cnt   = cnt_reg;

endmodule

[hw/rtl/pdt_div.sv]
// ----------------------------------------------------------------------------
// Radix-2 restoring divider
// One quotient bit per cycle; quotient and remainder hold after done.
// ----------------------------------------------------------------------------
module pdt_div #(
    parameter int WIDTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] dsr_reg;
    logic [WIDTH:0]   shifted;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[WIDTH-1]};
    assign fits    = shifted >= {1'b0, dsr_reg};
    assign done    = busy_reg && (cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(WIDTH);
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            if (fits)
            begin
                rem_reg <= WIDTH'(shifted - {1'b0, dsr_reg});
            end
            else
            begin
                rem_reg <= shifted[WIDTH-1:0];
            end
            quo_reg <= {quo_reg[WIDTH-2:0], fits};
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[hw/rtl/periodic_deadline_timer_bank.sv]
// ----------------------------------------------------------------------------
// Periodic deadline timer bank
// Slots kept in a rotating ring of cells; a sequencer arms, stops and expires.
// ----------------------------------------------------------------------------
// Input beats carry a request (arm, stop or tick) with the current time. The
// input stalls while a request is in progress; one request is handled at a
// time. Arm and stop each return one acknowledgement beat. A tick returns one
// beat per expired slot in deadline order, at most sixteen, or none at all.
// The final beat of a request has last set.
// Each ring pass shifts every slot past the head, then closes in ST_PASS_END.
// Arm or stop takes one pass, after a division when a periodic arm's start
// time lies in the past. A tick takes one pass per expiry plus one, and each
// periodic expiry adds a division; results then drain one beat per cycle
// while the output is not stalled. A stalled output holds its beat; the
// sequencer waits.
// Reset clears every slot to inactive with zero deadline, interval and count.
// ----------------------------------------------------------------------------
module periodic_deadline_timer_bank #(
    parameter int NUM_TIMERS = 16,
    parameter int TIME_BITS  = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [3:0]  slot,
    input  logic [63:0] start_time,
    input  logic [63:0] period,
    input  logic [63:0] now_time,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [3:0]  timer_id,
    output logic [63:0] old_deadline,
    output logic [63:0] old_period,
    output logic        was_armed,
    output logic [31:0] overrun_count,
    output logic [63:0] earliest_deadline,
    output logic        any_armed,
    output logic        last
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CMP_W = (IDX_W > pdt_pkg::SLOT_BITS) ? IDX_W : pdt_pkg::SLOT_BITS;
    localparam int CW    = pdt_pkg::COUNT_BITS;
    localparam int RCW   = pdt_pkg::RES_CNT_W;
    localparam int RIW   = pdt_pkg::RES_IDX_W;
    localparam int NRES  = pdt_pkg::RESULT_LIMIT;
    localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};
    localparam logic [CW-1:0]        CMAX = {CW{1'b1}};

    pdt_pkg::state_t state_reg, state_next;

    logic                 is_tick_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [3:0]           slot_reg;
    logic [IDX_W-1:0]     pass_cnt_reg;

    logic                 upd_pend_reg;
    logic [CMP_W-1:0]     upd_idx_reg;
    logic [TIME_BITS-1:0] upd_dl_reg;
    logic [TIME_BITS-1:0] upd_per_reg;
    logic [CW-1:0]        upd_cnt_reg;
    logic                 upd_armed_reg;
    logic                 upd_done_reg;

    logic [TIME_BITS-1:0] old_dl_reg;
    logic [TIME_BITS-1:0] old_per_reg;
    logic [CW-1:0]        old_cnt_reg;
    logic                 old_armed_reg;

    logic                 best_found_reg;
    logic [CMP_W-1:0]     best_idx_reg;
    logic [TIME_BITS-1:0] best_dl_reg;
    logic [TIME_BITS-1:0] best_per_reg;
    logic [CW-1:0]        best_cnt_reg;

    logic [TIME_BITS-1:0] earl_reg;
    logic                 any_reg;
    logic [RCW-1:0]       res_cnt_reg;
    logic [RCW-1:0]       rd_ptr_reg;

    logic                 buf_kind [NRES];
    logic [3:0]           buf_id [NRES];
    logic [TIME_BITS-1:0] buf_dl [NRES];
    logic [TIME_BITS-1:0] buf_per [NRES];
    logic                 buf_armed [NRES];
    logic [CW-1:0]        buf_cnt [NRES];

    logic                 out_valid_reg;
    logic                 out_kind_reg;
    logic [3:0]           out_id_reg;
    logic [TIME_BITS-1:0] out_dl_reg;
    logic [TIME_BITS-1:0] out_per_reg;
    logic                 out_armed_reg;
    logic [CW-1:0]        out_cnt_reg;
    logic [TIME_BITS-1:0] out_earl_reg;
    logic                 out_any_reg;
    logic                 out_last_reg;

    // Ring of slot cells; cell 0 is the head seen by the sequencer.
    logic                 c_armed [NUM_TIMERS];
    logic                 c_done [NUM_TIMERS];
    logic [TIME_BITS-1:0] c_dl [NUM_TIMERS];
    logic [TIME_BITS-1:0] c_per [NUM_TIMERS];
    logic [CW-1:0]        c_cnt [NUM_TIMERS];
    pdt_pkg::cell_ctrl_t  cell_ctrl;

    logic                 h_armed;
    logic                 h_done;
    logic [TIME_BITS-1:0] h_dl;
    logic [TIME_BITS-1:0] h_per;
    logic [CW-1:0]        h_cnt;
    logic                 head_match;
    logic                 pass_first;
    logic                 pass_last;
    logic                 eligible;

    logic                 in_acc;
    logic                 arm_clear;
    logic                 arm_div;
    logic                 out_free;
    logic                 emit_last;

    logic                 div_start;
    logic [TIME_BITS-1:0] div_dividend;
    logic [TIME_BITS-1:0] div_divisor;
    logic                 div_done;
    logic [TIME_BITS-1:0] div_q;
    logic [TIME_BITS-1:0] div_r;

    logic [TIME_BITS-1:0] per_sel;
    logic [TIME_BITS-1:0] base;
    logic [TIME_BITS-1:0] adv_dl;
    logic [63:0]          q_wide;
    logic [CW-1:0]        q_sat;
    logic [CW:0]          cnt_sum;
    logic [CW-1:0]        cnt_add;

    logic [TIME_BITS-1:0] in_start;
    logic [TIME_BITS-1:0] in_per;
    logic [TIME_BITS-1:0] in_now;

    assign in_start = start_time[TIME_BITS-1:0];
    assign in_per   = period[TIME_BITS-1:0];
    assign in_now   = now_time[TIME_BITS-1:0];

    assign in_stall  = (state_reg != pdt_pkg::ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign arm_clear = (req_type == pdt_pkg::REQ_STOP) || ((in_start == '0) && (in_per == '0));
    assign arm_div   = !arm_clear && (in_per != '0) && (in_start < in_now);
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit_last = (rd_ptr_reg == RCW'(res_cnt_reg - 1'b1));

    assign cell_ctrl.shift    = (state_reg == pdt_pkg::ST_PASS);
    assign cell_ctrl.clr_done = in_acc && (req_type == pdt_pkg::REQ_TICK);

    genvar gi;
    generate
        for (gi = 0; gi < NUM_TIMERS; gi++)
        begin : g_ring
            logic                 n_armed;
            logic                 n_done;
            logic [TIME_BITS-1:0] n_dl;
            logic [TIME_BITS-1:0] n_per;
            logic [CW-1:0]        n_cnt;

            if (gi == NUM_TIMERS - 1)
            begin : g_tail
                assign n_armed = h_armed;
                assign n_done  = h_done;
                assign n_dl    = h_dl;
                assign n_per   = h_per;
                assign n_cnt   = h_cnt;
            end
            else
            begin : g_mid
                assign n_armed = c_armed[gi+1];
                assign n_done  = c_done[gi+1];
                assign n_dl    = c_dl[gi+1];
                assign n_per   = c_per[gi+1];
                assign n_cnt   = c_cnt[gi+1];
            end

            pdt_cell #(
                .TIME_BITS (TIME_BITS)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (cell_ctrl),
                .d_armed (n_armed),
                .d_done  (n_done),
                .d_dl    (n_dl),
                .d_per   (n_per),
                .d_cnt   (n_cnt),
                .q_armed (c_armed[gi]),
                .q_done  (c_done[gi]),
                .q_dl    (c_dl[gi]),
                .q_per   (c_per[gi]),
                .q_cnt   (c_cnt[gi])
            );
        end
    endgenerate

    // A pending update replaces the head slot as it goes around.
    assign head_match = upd_pend_reg && (upd_idx_reg == CMP_W'(pass_cnt_reg));
    assign h_armed    = head_match ? upd_armed_reg : c_armed[0];
    assign h_done     = head_match ? upd_done_reg  : c_done[0];
    assign h_dl       = head_match ? upd_dl_reg    : c_dl[0];
    assign h_per      = head_match ? upd_per_reg   : c_per[0];
    assign h_cnt      = head_match ? upd_cnt_reg   : c_cnt[0];
    assign pass_first = (pass_cnt_reg == '0);
    assign pass_last  = (pass_cnt_reg == IDX_W'(NUM_TIMERS - 1));
    assign eligible   = is_tick_reg && (res_cnt_reg < RCW'(NRES)) && h_armed && !h_done
                        && (h_dl <= now_reg);

    // Deadline advance past now: base is the last period boundary not after now.
    assign per_sel = (state_reg == pdt_pkg::ST_ARM_DIV) ? upd_per_reg : best_per_reg;
    assign base    = now_reg - div_r;
    assign adv_dl  = (per_sel > ~base) ? TMAX : base + per_sel;
    assign q_wide  = 64'(div_q);
    assign q_sat   = (|q_wide[63:32]) ? CMAX : q_wide[31:0];
    assign cnt_sum = {1'b0, best_cnt_reg} + {1'b0, q_sat};
    assign cnt_add = cnt_sum[CW] ? CMAX : cnt_sum[CW-1:0];

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = in_now - in_start;
        div_divisor  = in_per;
        if (state_reg == pdt_pkg::ST_PASS_END)
        begin
            div_dividend = now_reg - best_dl_reg;
            div_divisor  = best_per_reg;
            div_start    = is_tick_reg && best_found_reg && (best_per_reg != '0);
        end
        else if (in_acc && (req_type == pdt_pkg::REQ_ARM) && arm_div)
        begin
            div_start = 1'b1;
        end
    end

    pdt_div #(
        .WIDTH (TIME_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pdt_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    priority if (req_type == pdt_pkg::REQ_TICK)
                    begin
                        state_next = pdt_pkg::ST_PASS;
                    end
                    else if (req_type == pdt_pkg::REQ_ARM || req_type == pdt_pkg::REQ_STOP)
                    begin
                        state_next = (req_type == pdt_pkg::REQ_ARM && arm_div)
                                     ? pdt_pkg::ST_ARM_DIV : pdt_pkg::ST_PASS;
                    end
                    else
                    begin
                        state_next = pdt_pkg::ST_IDLE;
                    end
                end
            end
            pdt_pkg::ST_ARM_DIV:
            begin
                if (div_done)
                begin
                    state_next = pdt_pkg::ST_PASS;
                end
            end
            pdt_pkg::ST_PASS:
            begin
                if (pass_last)
                begin
                    state_next = pdt_pkg::ST_PASS_END;
                end
            end
            pdt_pkg::ST_PASS_END:
            begin
                priority if (!is_tick_reg || !best_found_reg)
                begin
                    state_next = pdt_pkg::ST_EMIT;
                end
                else if (best_per_reg == '0)
                begin
                    state_next = pdt_pkg::ST_PASS;
                end
                else
                begin
                    state_next = pdt_pkg::ST_TICK_DIV;
                end
            end
            pdt_pkg::ST_TICK_DIV:
            begin
                if (div_done)
                begin
                    state_next = pdt_pkg::ST_PASS;
                end
            end
            pdt_pkg::ST_EMIT:
            begin
                if (res_cnt_reg == '0 || (out_free && emit_last))
                begin
                    state_next = pdt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pdt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pdt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencer control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_tick_reg    <= 1'b0;
            pass_cnt_reg   <= '0;
            upd_pend_reg   <= 1'b0;
            best_found_reg <= 1'b0;
            any_reg        <= 1'b0;
            res_cnt_reg    <= '0;
            rd_ptr_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                pdt_pkg::ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        is_tick_reg  <= (req_type == pdt_pkg::REQ_TICK);
                        upd_pend_reg <= (req_type != pdt_pkg::REQ_TICK);
                        pass_cnt_reg <= '0;
                        res_cnt_reg  <= '0;
                        rd_ptr_reg   <= '0;
                    end
                end
                pdt_pkg::ST_ARM_DIV:
                begin
                end
                pdt_pkg::ST_PASS:
                begin
                    pass_cnt_reg <= pass_last ? '0 : IDX_W'(pass_cnt_reg + 1'b1);
                    if (pass_last)
                    begin
                        upd_pend_reg <= 1'b0;
                    end
                    if (h_armed)
                    begin
                        any_reg <= 1'b1;
                    end
                    else if (pass_first)
                    begin
                        any_reg <= 1'b0;
                    end
                    if (eligible && (pass_first || !best_found_reg || h_dl < best_dl_reg))
                    begin
                        best_found_reg <= 1'b1;
                    end
                    else if (pass_first)
                    begin
                        best_found_reg <= 1'b0;
                    end
                end
                pdt_pkg::ST_PASS_END:
                begin
                    if (!is_tick_reg)
                    begin
                        res_cnt_reg <= RCW'(1);
                    end
                    else if (best_found_reg && best_per_reg == '0)
                    begin
                        res_cnt_reg  <= RCW'(res_cnt_reg + 1'b1);
                        upd_pend_reg <= 1'b1;
                    end
                end
                pdt_pkg::ST_TICK_DIV:
                begin
                    if (div_done)
                    begin
                        res_cnt_reg  <= RCW'(res_cnt_reg + 1'b1);
                        upd_pend_reg <= 1'b1;
                    end
                end
                pdt_pkg::ST_EMIT:
                begin
                    if (res_cnt_reg != '0 && out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        rd_ptr_reg    <= RCW'(rd_ptr_reg + 1'b1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            pdt_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    now_reg       <= in_now;
                    slot_reg      <= slot;
                    upd_idx_reg   <= CMP_W'(slot);
                    old_dl_reg    <= '0;
                    old_per_reg   <= '0;
                    old_cnt_reg   <= '0;
                    old_armed_reg <= 1'b0;
                    upd_done_reg  <= 1'b0;
                    upd_cnt_reg   <= '0;
                    if (arm_clear)
                    begin
                        upd_dl_reg    <= '0;
                        upd_per_reg   <= '0;
                        upd_armed_reg <= 1'b0;
                    end
                    else
                    begin
                        upd_dl_reg    <= in_start;
                        upd_per_reg   <= in_per;
                        upd_armed_reg <= 1'b1;
                    end
                end
            end
            pdt_pkg::ST_ARM_DIV:
            begin
                if (div_done)
                begin
                    upd_dl_reg  <= adv_dl;
                    upd_cnt_reg <= q_sat;
                end
            end
            pdt_pkg::ST_PASS:
            begin
                if (head_match && !is_tick_reg)
                begin
                    old_dl_reg    <= c_dl[0];
                    old_per_reg   <= c_per[0];
                    old_cnt_reg   <= c_cnt[0];
                    old_armed_reg <= c_armed[0];
                end
                if (h_armed && (pass_first || !any_reg || h_dl < earl_reg))
                begin
                    earl_reg <= h_dl;
                end
                else if (pass_first)
                begin
                    earl_reg <= '0;
                end
                if (eligible && (pass_first || !best_found_reg || h_dl < best_dl_reg))
                begin
                    best_idx_reg <= CMP_W'(pass_cnt_reg);
                    best_dl_reg  <= h_dl;
                    best_per_reg <= h_per;
                    best_cnt_reg <= h_cnt;
                end
            end
            pdt_pkg::ST_PASS_END:
            begin
                if (!is_tick_reg)
                begin
                    buf_kind[0]  <= pdt_pkg::KIND_ACK;
                    buf_id[0]    <= slot_reg;
                    buf_dl[0]    <= old_dl_reg;
                    buf_per[0]   <= old_per_reg;
                    buf_armed[0] <= old_armed_reg;
                    buf_cnt[0]   <= old_cnt_reg;
                end
                else if (best_found_reg && best_per_reg == '0)
                begin
                    // One-shot expiry: disarm and keep the missed count.
                    buf_kind[res_cnt_reg[RIW-1:0]]  <= pdt_pkg::KIND_EXPIRY;
                    buf_id[res_cnt_reg[RIW-1:0]]    <= best_idx_reg[3:0];
                    buf_dl[res_cnt_reg[RIW-1:0]]    <= best_dl_reg;
                    buf_per[res_cnt_reg[RIW-1:0]]   <= best_per_reg;
                    buf_armed[res_cnt_reg[RIW-1:0]] <= 1'b1;
                    buf_cnt[res_cnt_reg[RIW-1:0]]   <= best_cnt_reg;
                    upd_idx_reg   <= best_idx_reg;
                    upd_dl_reg    <= '0;
                    upd_per_reg   <= '0;
                    upd_cnt_reg   <= best_cnt_reg;
                    upd_armed_reg <= 1'b0;
                    upd_done_reg  <= 1'b1;
                end
            end
            pdt_pkg::ST_TICK_DIV:
            begin
                if (div_done)
                begin
                    buf_kind[res_cnt_reg[RIW-1:0]]  <= pdt_pkg::KIND_EXPIRY;
                    buf_id[res_cnt_reg[RIW-1:0]]    <= best_idx_reg[3:0];
                    buf_dl[res_cnt_reg[RIW-1:0]]    <= best_dl_reg;
                    buf_per[res_cnt_reg[RIW-1:0]]   <= best_per_reg;
                    buf_armed[res_cnt_reg[RIW-1:0]] <= 1'b1;
                    buf_cnt[res_cnt_reg[RIW-1:0]]   <= cnt_add;
                    upd_idx_reg   <= best_idx_reg;
                    upd_dl_reg    <= adv_dl;
                    upd_per_reg   <= best_per_reg;
                    upd_cnt_reg   <= cnt_add;
                    upd_armed_reg <= 1'b1;
                    upd_done_reg  <= 1'b1;
                end
            end
            pdt_pkg::ST_EMIT:
            begin
                if (res_cnt_reg != '0 && out_free)
                begin
                    out_kind_reg  <= buf_kind[rd_ptr_reg[RIW-1:0]];
                    out_id_reg    <= buf_id[rd_ptr_reg[RIW-1:0]];
                    out_dl_reg    <= buf_dl[rd_ptr_reg[RIW-1:0]];
                    out_per_reg   <= buf_per[rd_ptr_reg[RIW-1:0]];
                    out_armed_reg <= buf_armed[rd_ptr_reg[RIW-1:0]];
                    out_cnt_reg   <= buf_cnt[rd_ptr_reg[RIW-1:0]];
                    out_earl_reg  <= earl_reg;
                    out_any_reg   <= any_reg;
                    out_last_reg  <= emit_last;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid         = out_valid_reg;
    assign result_kind       = out_kind_reg;
    assign timer_id          = out_id_reg;
    assign old_deadline      = pdt_pkg::PORT_TIME_W'(out_dl_reg);
    assign old_period        = pdt_pkg::PORT_TIME_W'(out_per_reg);
    assign was_armed         = out_armed_reg;
    assign overrun_count     = out_cnt_reg;
    assign earliest_deadline = pdt_pkg::PORT_TIME_W'(out_earl_reg);
    assign any_armed         = out_any_reg;
    assign last              = out_last_reg;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic deadline timer bank testbench
// Drives arm, stop, tick and reserved requests with random idling and compares every
// result beat against a cycle-free model of the sixteen timer slots.
// ----------------------------------------------------------------------------

typedef struct {
    logic        kind;
    logic [3:0]  id;
    logic [63:0] dl;
    logic [63:0] per;
    logic        armed;
    logic [31:0] cnt;
    logic [63:0] earliest;
    logic        any;
    logic        lst;
} timer_beat_t;

class timer_scoreboard;
    logic [63:0] deadlines [16];
    logic [63:0] periods [16];
    logic [31:0] overruns [16];
    logic        active [16];
    timer_beat_t pending[$];
    int          errors;
    int          acks;
    int          expiries;

    function new();
        for (int i = 0; i < 16; i++)
        begin
            deadlines[i] = 0;
            periods[i] = 0;
            overruns[i] = 0;
            active[i] = 0;
        end
        errors = 0;
        acks = 0;
        expiries = 0;
    endfunction

    // Moves a deadline past now by whole periods, returns the skipped count.
    function logic [63:0] skip_periods(ref logic [63:0] dl, input logic [63:0] now,
                                       input logic [63:0] p);
        logic [63:0] d;
        logic [63:0] base;
        d = now - dl;
        base = now - (d % p);
        if (p > 64'hFFFF_FFFF_FFFF_FFFF - base)
            dl = 64'hFFFF_FFFF_FFFF_FFFF;
        else
            dl = base + p;
        return d / p;
    endfunction

    function logic [31:0] clamp32(logic [64:0] v);
        return (v > 65'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function void note_request(logic [1:0] rq, logic [3:0] s, logic [63:0] st,
                               logic [63:0] p, logic [63:0] now);
        timer_beat_t b;
        timer_beat_t batch[$];
        logic        done [16];
        logic [63:0] dl;
        logic [63:0] k;
        logic [63:0] earliest;
        logic        any;
        int          best;
        if (rq == pdt_pkg::REQ_ARM || rq == pdt_pkg::REQ_STOP)
        begin
            b.kind = pdt_pkg::KIND_ACK;
            b.id = s;
            b.dl = deadlines[s];
            b.per = periods[s];
            b.armed = active[s];
            b.cnt = overruns[s];
            batch.insert(batch.size(), b);
            acks++;
            if (rq == pdt_pkg::REQ_STOP || (st == 0 && p == 0))
            begin
                deadlines[s] = 0;
                periods[s] = 0;
                overruns[s] = 0;
                active[s] = 0;
            end
            else
            begin
                dl = st;
                k = 0;
                if (p != 0 && st < now)
                    k = skip_periods(dl, now, p);
                deadlines[s] = dl;
                periods[s] = p;
                overruns[s] = clamp32({1'b0, k});
                active[s] = 1;
            end
        end
        else if (rq == pdt_pkg::REQ_TICK)
        begin
            for (int i = 0; i < 16; i++)
                done[i] = 0;
            while (batch.size() < pdt_pkg::RESULT_LIMIT)
            begin
                best = -1;
                for (int i = 0; i < 16; i++)
                begin
                    if (!active[i] || done[i] || deadlines[i] > now)
                        continue;
                    if (best < 0 || deadlines[i] < deadlines[best])
                        best = i;
                end
                if (best < 0)
                    break;
                done[best] = 1;
                b.kind = pdt_pkg::KIND_EXPIRY;
                b.id = best[3:0];
                b.dl = deadlines[best];
                b.per = periods[best];
                b.armed = 1;
                if (periods[best] == 0)
                begin
                    active[best] = 0;
                    deadlines[best] = 0;
                end
                else
                begin
                    dl = deadlines[best];
                    k = skip_periods(dl, now, periods[best]);
                    deadlines[best] = dl;
                    overruns[best] = clamp32({33'd0, overruns[best]}
                                             + {1'b0, (k > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : k});
                end
                b.cnt = overruns[best];
                batch.insert(batch.size(), b);
                expiries++;
            end
        end
        earliest = 0;
        any = 0;
        for (int i = 0; i < 16; i++)
        begin
            if (!active[i])
                continue;
            if (!any || deadlines[i] < earliest)
                earliest = deadlines[i];
            any = 1;
        end
        foreach (batch[j])
        begin
            batch[j].earliest = earliest;
            batch[j].any = any;
            batch[j].lst = (j == batch.size() - 1);
            pending.insert(pending.size(), batch[j]);
        end
    endfunction

    function void check_field(string name, logic [63:0] exp, logic [63:0] act);
        if (exp !== act)
        begin
            $error("%s: expected %h, got %h", name, exp, act);
            errors++;
        end
    endfunction

    function void check_result(timer_beat_t a);
        timer_beat_t e;
        if (pending.size() == 0)
        begin
            $error("result beat with nothing expected");
            errors++;
            return;
        end
        e = pending.pop_front();
        check_field("result_kind", e.kind, a.kind);
        check_field("timer_id", e.id, a.id);
        check_field("old_deadline", e.dl, a.dl);
        check_field("old_period", e.per, a.per);
        check_field("was_armed", e.armed, a.armed);
        check_field("overrun_count", e.cnt, a.cnt);
        check_field("earliest_deadline", e.earliest, a.earliest);
        check_field("any_armed", e.any, a.any);
        check_field("last", e.lst, a.lst);
    endfunction
endclass

module testbench;
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  req_type;
    logic [3:0]  slot;
    logic [63:0] start_time;
    logic [63:0] period;
    logic [63:0] now_time;
    logic        out_valid;
    logic        out_stall;
    logic        result_kind;
    logic [3:0]  timer_id;
    logic [63:0] old_deadline;
    logic [63:0] old_period;
    logic        was_armed;
    logic [31:0] overrun_count;
    logic [63:0] earliest_deadline;
    logic        any_armed;
    logic        last;

    timer_scoreboard sb;
    logic [63:0] clock_now;
    bit          quiet;
    bit          hold_off;
    int          idle_cycles = 0;
    int          stall_left = 0;
    int          requests;

    periodic_deadline_timer_bank uut (.*);

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // The beat stays offered after acceptance until the next call or drain.
    task automatic send_beat(logic [1:0] rq, logic [3:0] s, logic [63:0] st,
                             logic [63:0] p, logic [63:0] now);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rq;
        slot <= s;
        start_time <= st;
        period <= p;
        now_time <= now;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(rq, s, st, p, now);
        requests++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        // A tick with no expiry returns nothing but still runs one ring pass.
        repeat (200) @(negedge clk);
    endtask

    // Mostly well-formed traffic: small periods, time marching forward, frequent ticks.
    task automatic random_request();
        int pick;
        logic [63:0] st;
        logic [63:0] p;
        pick = $urandom_range(0, 9);
        clock_now = clock_now + 64'($urandom_range(0, 40));
        if (pick < 3)
        begin
            p = ($urandom_range(0, 3) == 0) ? 64'd0 : 64'($urandom_range(1, 30));
            st = clock_now + 64'($urandom_range(0, 60)) - 64'd30;
            if ($urandom_range(0, 15) == 0)
            begin
                st = rand64();
                p = rand64();
            end
            send_beat(pdt_pkg::REQ_ARM, 4'($urandom_range(0, 15)), st, p, clock_now);
        end
        else if (pick == 3)
            send_beat(pdt_pkg::REQ_STOP, 4'($urandom_range(0, 15)), rand64(), rand64(),
                      clock_now);
        else if (pick == 4 && $urandom_range(0, 3) == 0)
            send_beat(pdt_pkg::REQ_RSVD, 4'($urandom_range(0, 15)), rand64(), rand64(),
                      rand64());
        else
            send_beat(pdt_pkg::REQ_TICK, 4'($urandom_range(0, 15)), rand64(), rand64(),
                      clock_now);
    endtask

    always @(posedge clk)
    begin
        timer_beat_t r;
        if (rst_n && out_valid && !out_stall)
        begin
            r.kind = result_kind;
            r.id = timer_id;
            r.dl = old_deadline;
            r.per = old_period;
            r.armed = was_armed;
            r.cnt = overrun_count;
            r.earliest = earliest_deadline;
            r.any = any_armed;
            r.lst = last;
            sb.check_result(r);
        end
    end

    // Receiver idling comes in bursts of random length.
    always @(negedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(0, 4);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        quiet = 0;
        hold_off = 0;
        requests = 0;
        clock_now = 1000;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        req_type = pdt_pkg::REQ_TICK;
        slot = 0;
        start_time = 0;
        period = 0;
        now_time = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        repeat (40) @(negedge clk);

        // Directed: extremes, overflow, saturation, ties, unused code.
        send_beat(pdt_pkg::REQ_STOP, 4'd0, 0, 0, 0);
        send_beat(pdt_pkg::REQ_ARM, 4'd1, 64'd100, 64'd0, 64'd50);
        send_beat(pdt_pkg::REQ_ARM, 4'd2, 64'd100, 64'd10, 64'd50);
        send_beat(pdt_pkg::REQ_ARM, 4'd3, 64'd10, 64'd7, 64'd100);
        send_beat(pdt_pkg::REQ_ARM, 4'd4, 64'd0, 64'd0, 64'd100);
        send_beat(pdt_pkg::REQ_TICK, 4'd0, 0, 0, 64'd99);
        send_beat(pdt_pkg::REQ_TICK, 4'd0, 0, 0, 64'd100);
        send_beat(pdt_pkg::REQ_ARM, 4'd5, 64'd0, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(pdt_pkg::REQ_ARM, 4'd6, 64'hFFFF_FFFF_FFFF_FFF0, 64'h8000_0000_0000_0000,
                  64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(pdt_pkg::REQ_ARM, 4'd15, 64'd5000, 64'd3, 64'd5000);
        send_beat(pdt_pkg::REQ_ARM, 4'd14, 64'd5000, 64'd0, 64'd0);
        send_beat(pdt_pkg::REQ_TICK, 4'd0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(pdt_pkg::REQ_TICK, 4'd0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(pdt_pkg::REQ_ARM, 4'd5, 64'd1, 64'd1, 64'd0);
        send_beat(pdt_pkg::REQ_STOP, 4'd5, 0, 0, 0);
        send_beat(pdt_pkg::REQ_RSVD, 4'd7, 64'd1, 64'd1, 64'd1);
        for (int i = 0; i < 16; i++)
            send_beat(pdt_pkg::REQ_ARM, i[3:0], 64'd2000, 64'd1 + 64'(i % 2), 64'd1500);
        send_beat(pdt_pkg::REQ_TICK, 4'd0, 0, 0, 64'd3000);
        drain();

        // Receiver holds off while requests keep coming.
        hold_off = 1;
        fork
            begin
                repeat (300) @(negedge clk);
                hold_off = 0;
            end
            repeat (12) random_request();
        join
        drain();

        for (int n = 0; n < 140; n++)
        begin
            if (n == 105)
                quiet = 1;
            random_request();
            if (n % 60 == 59)
                drain();
        end
        drain();

        $display("Sent %0d requests: %0d acknowledgements and %0d expiries checked.",
                 requests, sb.acks, sb.expiries);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
